>>> rtl/qlsf_pkg.sv
// Types, widths and the determinant micro-program for the quadratic fit.
package qlsf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CNT_W    = 11;
  localparam int COEF_W   = 48;
  localparam int ENT_W    = 56;
  localparam int WIDE     = 144;
  localparam int OP_W     = 4;
  localparam int LAST_OP  = 8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_value;
    logic signed [SAMPLE_W-1:0] y_value;
    logic                       last_point;
  } point_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_square;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_constant;
    logic                     singular;
    logic [CNT_W-1:0]         point_count;
  } fit_t;

  // dst = (clr ? 0 : dst) +/- m[mul_idx] * (src_t ? T : m[src_idx])
  typedef struct packed {
    logic [3:0] mul_idx;
    logic [3:0] src_idx;
    logic       src_t;
    logic       dst_r;
    logic       neg;
    logic       clr;
  } mac_op_t;

  function automatic mac_op_t mac_op(logic [OP_W-1:0] i);
    mac_op_t o;
    case (i)
      4'd0:    o = '{4'd4, 4'd8, 1'b0, 1'b0, 1'b0, 1'b1};
      4'd1:    o = '{4'd5, 4'd7, 1'b0, 1'b0, 1'b1, 1'b0};
      4'd2:    o = '{4'd0, 4'd0, 1'b1, 1'b1, 1'b0, 1'b1};
      4'd3:    o = '{4'd3, 4'd8, 1'b0, 1'b0, 1'b0, 1'b1};
      4'd4:    o = '{4'd5, 4'd6, 1'b0, 1'b0, 1'b1, 1'b0};
      4'd5:    o = '{4'd1, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0};
      4'd6:    o = '{4'd3, 4'd7, 1'b0, 1'b0, 1'b0, 1'b1};
      4'd7:    o = '{4'd4, 4'd6, 1'b0, 1'b0, 1'b1, 1'b0};
      4'd8:    o = '{4'd2, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0};
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

>>> rtl/quadratic_least_squares_fit.sv
// Quadratic least-squares fit: point accumulation and Cramer solve.
// Points: an accept plus six steps of the shared 25x25 multiplier each.
// Fit after a last point: up to four 3x3 determinants of nine shift-add MACs
// each (only the first if the system is singular), then up to three restoring
// divisions; no points are taken until the result is committed.
// Reset clears all sums, the sequencer and the result valid flag.
module quadratic_least_squares_fit #(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_WIDTH = 12,
  parameter int FRAC_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_stall,
  input  qlsf_pkg::point_t  point,
  output logic              fit_valid,
  input  logic              fit_stall,
  output qlsf_pkg::fit_t    fit
);
  import qlsf_pkg::*;

  localparam int SHIFT = SAMPLE_W - SAMPLE_WIDTH;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACC      = 4'd1;
  localparam logic [3:0] S_MAC_LOAD = 4'd2;
  localparam logic [3:0] S_MAC_RUN  = 4'd3;
  localparam logic [3:0] S_MAC_DONE = 4'd4;
  localparam logic [3:0] S_DET_DONE = 4'd5;
  localparam logic [3:0] S_DIV_LOAD = 4'd6;
  localparam logic [3:0] S_DIV_RUN  = 4'd7;
  localparam logic [3:0] S_DIV_DONE = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  localparam logic [1:0] MAT_DET = 2'd0;
  localparam logic [1:0] MAT_C   = 2'd1;
  localparam logic [1:0] MAT_B   = 2'd2;
  localparam logic [1:0] MAT_A   = 2'd3;

  logic [3:0] state;
  logic [2:0] step;
  logic [OP_W-1:0] op_idx;
  logic [1:0] mat;

  logic signed [SAMPLE_W-1:0] xs, ys, x_sample, y_sample;
  logic last;
  logic signed [24:0] x2;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;

  logic [CNT_W-1:0] count_points;
  logic signed [21:0] acc_x, acc_y;
  logic [32:0] acc_x_sq;
  logic signed [33:0] acc_xy;
  logic signed [43:0] acc_x_cube, acc_x_sq_y;
  logic [54:0] acc_x_quad;

  logic signed [WIDE-1:0] w, mcand, t_reg, r_reg, den, mac_prod, mac_base;
  logic [ENT_W-1:0] mbits;
  logic [5:0] bitcnt;
  logic flip;
  mac_op_t cur_op;
  logic signed [ENT_W-1:0] ent_mul, ent_src;

  logic [WIDE-1:0] dn, dd, abs_r, abs_d;
  logic [WIDE:0] rm, rsh;
  logic [7:0] dcnt;
  logic qneg, q_big, q_over;
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_new;
  logic singular;

  function automatic logic signed [ENT_W-1:0] pick(
    logic [3:0] idx, logic [1:0] m,
    logic signed [ENT_W-1:0] e_n, e_x, e_x2, e_x3, e_x4, e_y, e_xy, e_x2y);
    logic signed [ENT_W-1:0] v;
    case (idx)
      4'd0:    v = (m == MAT_C) ? e_y   : e_n;
      4'd1:    v = (m == MAT_B) ? e_y   : e_x;
      4'd2:    v = (m == MAT_A) ? e_y   : e_x2;
      4'd3:    v = (m == MAT_C) ? e_xy  : e_x;
      4'd4:    v = (m == MAT_B) ? e_xy  : e_x2;
      4'd5:    v = (m == MAT_A) ? e_xy  : e_x3;
      4'd6:    v = (m == MAT_C) ? e_x2y : e_x2;
      4'd7:    v = (m == MAT_B) ? e_x2y : e_x3;
      4'd8:    v = (m == MAT_A) ? e_x2y : e_x4;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign point_stall = (state != S_IDLE);
  assign cur_op = mac_op(op_idx);

  always_comb begin
    x_sample = $signed(point.x_value) <<< SHIFT;
    x_sample = x_sample >>> SHIFT;
    y_sample = $signed(point.y_value) <<< SHIFT;
    y_sample = y_sample >>> SHIFT;
  end

  always_comb begin
    case (step)
      3'd0:    begin mul_a = 25'(xs);  mul_b = 25'(xs); end
      3'd1:    begin mul_a = prod[24:0]; mul_b = 25'(xs); end
      3'd2:    begin mul_a = x2;       mul_b = x2; end
      3'd3:    begin mul_a = 25'(xs);  mul_b = 25'(ys); end
      3'd4:    begin mul_a = x2;       mul_b = 25'(ys); end
      default: begin mul_a = '0;       mul_b = '0; end
    endcase
  end

  always_comb begin
    ent_mul = pick(cur_op.mul_idx, mat, ENT_W'({1'b0, count_points}), ENT_W'(acc_x),
                   ENT_W'(acc_x_sq), ENT_W'(acc_x_cube), ENT_W'(acc_x_quad),
                   ENT_W'(acc_y), ENT_W'(acc_xy), ENT_W'(acc_x_sq_y));
    ent_src = pick(cur_op.src_idx, mat, ENT_W'({1'b0, count_points}), ENT_W'(acc_x),
                   ENT_W'(acc_x_sq), ENT_W'(acc_x_cube), ENT_W'(acc_x_quad),
                   ENT_W'(acc_y), ENT_W'(acc_xy), ENT_W'(acc_x_sq_y));
    mac_prod = flip ? -w : w;
    mac_base = cur_op.clr ? '0 : (cur_op.dst_r ? r_reg : t_reg);
    abs_r = r_reg[WIDE-1] ? WIDE'(-r_reg) : WIDE'(r_reg);
    abs_d = den[WIDE-1] ? WIDE'(-den) : WIDE'(den);
    rsh = {rm[WIDE-1:0], dn[WIDE-1]};
    q_big  = |dn[WIDE-1:COEF_W-1];
    q_over = (|dn[WIDE-1:COEF_W]) || (dn[COEF_W-1] && (|dn[COEF_W-2:0]));
    if (!qneg) begin
      coef_new = q_big ? {1'b0, {(COEF_W-1){1'b1}}} : dn[COEF_W-1:0];
    end else begin
      coef_new = q_over ? {1'b1, {(COEF_W-1){1'b0}}} : -dn[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      op_idx <= '0;
      mat <= MAT_DET;
      fit_valid <= 1'b0;
      count_points <= '0;
      acc_x <= '0;
      acc_y <= '0;
      acc_x_sq <= '0;
      acc_x_cube <= '0;
      acc_x_quad <= '0;
      acc_xy <= '0;
      acc_x_sq_y <= '0;
    end else begin
      if (fit_valid && !fit_stall && state != S_OUT) begin
        fit_valid <= 1'b0;
      end
      prod <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (point_valid) begin
            xs <= x_sample;
            ys <= y_sample;
            last <= point.last_point;
            step <= '0;
            op_idx <= '0;
            mat <= MAT_DET;
            if (count_points < CNT_W'(MAX_POINTS)) begin
              state <= S_ACC;
            end else if (point.last_point) begin
              state <= S_MAC_LOAD;
            end
          end
        end
        S_ACC: begin
          step <= step + 3'd1;
          case (step)
            3'd1: begin
              acc_x_sq <= acc_x_sq + prod[32:0];
              x2 <= prod[24:0];
            end
            3'd2: acc_x_cube <= acc_x_cube + prod[43:0];
            3'd3: acc_x_quad <= acc_x_quad + 55'(prod);
            3'd4: acc_xy <= acc_xy + prod[33:0];
            3'd5: begin
              acc_x_sq_y <= acc_x_sq_y + prod[43:0];
              acc_x <= acc_x + 22'(xs);
              acc_y <= acc_y + 22'(ys);
              count_points <= count_points + CNT_W'(1);
              state <= last ? S_MAC_LOAD : S_IDLE;
            end
            default: ;
          endcase
        end
        S_MAC_LOAD: begin
          flip <= ent_mul[ENT_W-1] ^ cur_op.neg;
          mbits <= ent_mul[ENT_W-1] ? ENT_W'(-ent_mul) : ENT_W'(ent_mul);
          mcand <= cur_op.src_t ? t_reg : WIDE'(ent_src);
          w <= '0;
          bitcnt <= '0;
          state <= S_MAC_RUN;
        end
        S_MAC_RUN: begin
          w <= (w <<< 1) + (mbits[ENT_W-1] ? mcand : '0);
          mbits <= mbits << 1;
          bitcnt <= bitcnt + 6'd1;
          if (bitcnt == 6'(ENT_W - 1)) begin
            state <= S_MAC_DONE;
          end
        end
        S_MAC_DONE: begin
          if (cur_op.dst_r) begin
            r_reg <= mac_base + mac_prod;
          end else begin
            t_reg <= mac_base + mac_prod;
          end
          if (op_idx == OP_W'(LAST_OP)) begin
            state <= S_DET_DONE;
          end else begin
            op_idx <= op_idx + OP_W'(1);
            state <= S_MAC_LOAD;
          end
        end
        S_DET_DONE: begin
          op_idx <= '0;
          if (mat == MAT_DET) begin
            den <= r_reg;
            if (r_reg == '0) begin
              singular <= 1'b1;
              coef_a <= '0;
              coef_b <= '0;
              coef_c <= '0;
              state <= S_OUT;
            end else begin
              singular <= 1'b0;
              mat <= MAT_C;
              state <= S_MAC_LOAD;
            end
          end else begin
            state <= S_DIV_LOAD;
          end
        end
        S_DIV_LOAD: begin
          dn <= (abs_r << (FRAC_BITS + 1)) + abs_d;
          dd <= abs_d << 1;
          rm <= '0;
          dcnt <= '0;
          qneg <= r_reg[WIDE-1] ^ den[WIDE-1];
          state <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          if (rsh >= {1'b0, dd}) begin
            rm <= rsh - {1'b0, dd};
            dn <= {dn[WIDE-2:0], 1'b1};
          end else begin
            rm <= rsh;
            dn <= {dn[WIDE-2:0], 1'b0};
          end
          dcnt <= dcnt + 8'd1;
          if (dcnt == 8'(WIDE - 1)) begin
            state <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          case (mat)
            MAT_C:   coef_c <= coef_new;
            MAT_B:   coef_b <= coef_new;
            default: coef_a <= coef_new;
          endcase
          if (mat == MAT_A) begin
            state <= S_OUT;
          end else begin
            mat <= mat + 2'd1;
            state <= S_MAC_LOAD;
          end
        end
        S_OUT: begin
          if (!fit_valid || !fit_stall) begin
            fit.coef_square <= coef_a;
            fit.coef_linear <= coef_b;
            fit.coef_constant <= coef_c;
            fit.singular <= singular;
            fit.point_count <= count_points;
            fit_valid <= 1'b1;
            count_points <= '0;
            acc_x <= '0;
            acc_y <= '0;
            acc_x_sq <= '0;
            acc_x_cube <= '0;
            acc_x_quad <= '0;
            acc_xy <= '0;
            acc_x_sq_y <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(fit_valid) |-> $past(state) == S_OUT)
    else $error("result appeared outside commit");
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit.singular |->
      fit.coef_square == '0 && fit.coef_linear == '0 && fit.coef_constant == '0)
    else $error("singular fit with nonzero coefficients");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_points <= CNT_W'(MAX_POINTS))
    else $error("point count over limit");
`endif

endmodule

>>> sim/testbench.sv
// Testbench for quadratic_least_squares_fit: directed point sets, then random sets.
module testbench;
  import qlsf_pkg::*;

  typedef logic [255:0] wide_t;
  typedef wide_t mat_t [9];

  typedef struct {
    point_t p;
    bit     typed;
    fit_t   fixed;
  } row_t;

  logic   clk;
  logic   rst;
  logic   point_valid;
  logic   point_stall;
  point_t point;
  logic   fit_valid;
  logic   fit_stall;
  fit_t   fit;

  quadratic_least_squares_fit dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .fit_valid(fit_valid), .fit_stall(fit_stall), .fit(fit)
  );

  int     n_held;
  longint sx, sy, sx2, sx3, sx4, sxy, sx2y;
  fit_t   pending_fits[$];
  bit     failed;
  int     fits_seen;
  int     send_idle;
  int     recv_idle;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #250000000;
    $display("tb: failure");
    $finish;
  end

  function automatic wide_t widen(longint v);
    return {{192{v[63]}}, v};
  endfunction

  function automatic wide_t det3(mat_t m);
    wide_t t0, t1, t2;
    t0 = m[4] * m[8] - m[5] * m[7];
    t1 = m[3] * m[8] - m[5] * m[6];
    t2 = m[3] * m[7] - m[4] * m[6];
    return m[0] * t0 - m[1] * t1 + m[2] * t2;
  endfunction

  function automatic logic [47:0] scaled_ratio(wide_t num, wide_t den);
    bit          neg;
    wide_t       an, ad, q;
    logic [63:0] mag;
    neg = num[255] ^ den[255];
    an  = num[255] ? -num : num;
    ad  = den[255] ? -den : den;
    an  = (an << 17) + ad;
    q   = an / (ad << 1);
    if (q[255:64] != 0) return neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    mag = q[63:0];
    if (neg) begin
      if (mag > 64'h800000000000) mag = 64'h800000000000;
      return 48'(64'd0 - mag);
    end
    if (mag > 64'h7FFFFFFFFFFF) mag = 64'h7FFFFFFFFFFF;
    return mag[47:0];
  endfunction

  function automatic void clear_sums();
    n_held = 0;
    sx = 0; sy = 0; sx2 = 0; sx3 = 0; sx4 = 0; sxy = 0; sx2y = 0;
  endfunction

  // Updates the running sums; returns 1 with the fit on a last point.
  function automatic bit fit_points(point_t p, output fit_t f);
    longint      x, y, x2;
    mat_t        m, k;
    wide_t       rhs[3], det;
    logic [47:0] coef[3];
    if (n_held < 1024) begin
      x = p.x_value;
      y = p.y_value;
      x2 = x * x;
      n_held++;
      sx += x; sy += y; sx2 += x2; sx3 += x2 * x; sx4 += x2 * x2;
      sxy += x * y; sx2y += x2 * y;
    end
    f = '0;
    if (!p.last_point) return 0;
    m[0] = widen(n_held); m[1] = widen(sx);  m[2] = widen(sx2);
    m[3] = widen(sx);     m[4] = widen(sx2); m[5] = widen(sx3);
    m[6] = widen(sx2);    m[7] = widen(sx3); m[8] = widen(sx4);
    rhs[0] = widen(sy); rhs[1] = widen(sxy); rhs[2] = widen(sx2y);
    det = det3(m);
    for (int c = 0; c < 3; c++) begin
      k = m;
      for (int r = 0; r < 3; r++) k[r * 3 + c] = rhs[r];
      coef[c] = (det == 0) ? 48'd0 : scaled_ratio(det3(k), det);
    end
    f.coef_square   = coef[2];
    f.coef_linear   = coef[1];
    f.coef_constant = coef[0];
    f.singular      = (det == 0);
    f.point_count   = n_held[10:0];
    clear_sums();
    return 1;
  endfunction

  function automatic void set_idling(int sent);
    if (sent < 600) begin
      send_idle = 12; recv_idle = 80;
    end else if (sent < 1200) begin
      send_idle = 80; recv_idle = 12;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  endfunction

  task automatic offer(point_t p, bit typed, fit_t fixed);
    fit_t f;
    while ($urandom_range(99) < send_idle) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    point <= p;
    do @(posedge clk); while (point_stall);
    if (fit_points(p, f)) pending_fits.push_back(typed ? fixed : f);
  endtask

  function automatic point_t mk(int x, int y, bit last);
    point_t p;
    p.x_value = 12'(x);
    p.y_value = 12'(y);
    p.last_point = last;
    return p;
  endfunction

  function automatic fit_t sing(int n);
    fit_t f;
    f = '0;
    f.singular = 1'b1;
    f.point_count = 11'(n);
    return f;
  endfunction

  // Stimulus
  initial begin
    row_t   rows[$];
    int     sent, len, xr;
    point_t p;
    fit_t   none;
    none = '0;
    rst = 1; point_valid = 0; point = '0; fit_stall = 0;
    failed = 0; fits_seen = 0;
    clear_sums();
    set_idling(0);
    repeat (7) @(posedge clk);
    rst <= 0;

    rows.push_back('{mk(5, 7, 1), 1, sing(1)});
    rows.push_back('{mk(-2048, -2048, 0), 0, none});
    rows.push_back('{mk(2047, 2047, 1), 1, sing(2)});
    rows.push_back('{mk(1, 0, 0), 0, none});
    rows.push_back('{mk(1, 5, 0), 0, none});
    rows.push_back('{mk(1, -3, 1), 1, sing(3)});
    rows.push_back('{mk(0, 0, 0), 0, none});
    rows.push_back('{mk(1, 1, 0), 0, none});
    rows.push_back('{mk(2, 4, 1), 0, none});
    rows.push_back('{mk(-2048, 2047, 0), 0, none});
    rows.push_back('{mk(0, -2048, 0), 0, none});
    rows.push_back('{mk(2047, -1, 0), 0, none});
    rows.push_back('{mk(-1, 0, 1), 0, none});
    rows.push_back('{mk(-2048, -2048, 0), 0, none});
    rows.push_back('{mk(2047, 2047, 0), 0, none});
    rows.push_back('{mk(1, -1, 0), 0, none});
    rows.push_back('{mk(-1, 1, 0), 0, none});
    rows.push_back('{mk(100, 2047, 0), 0, none});
    rows.push_back('{mk(-100, -2048, 1), 0, none});
    rows.push_back('{mk(2047, 2047, 0), 0, none});
    rows.push_back('{mk(2046, -2048, 0), 0, none});
    rows.push_back('{mk(2045, 2047, 1), 0, none});
    sent = 0;
    foreach (rows[i]) begin
      offer(rows[i].p, rows[i].typed, rows[i].fixed);
      sent++;
    end

    while (sent < 1700) begin
      set_idling(sent);
      if (sent > 900 && sent < 1000) len = 1030;
      else if ($urandom_range(9) == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(3, 14);
      xr = ($urandom_range(4) == 0) ? 3 : 2047;
      for (int i = 0; i < len; i++) begin
        p.x_value = ($urandom_range(19) == 0) ? 12'($urandom)
                    : 12'($urandom_range(xr * 2) - xr);
        p.y_value = 12'($urandom);
        p.last_point = (i == len - 1) || (len < 1000 && $urandom_range(199) == 0);
        offer(p, 0, none);
        sent++;
      end
    end
    point_valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side
  initial begin
    fit_t e;
    forever begin
      @(posedge clk);
      if (!rst && fit_valid && !fit_stall) begin
        fits_seen++;
        if (pending_fits.size() == 0) begin
          $display("%0t unexpected fit %h", $time, fit);
          failed = 1;
        end else begin
          e = pending_fits.pop_front();
          if (fit.coef_square !== e.coef_square) begin
            $display("%0t coef_square exp %h got %h", $time, e.coef_square, fit.coef_square);
            failed = 1;
          end
          if (fit.coef_linear !== e.coef_linear) begin
            $display("%0t coef_linear exp %h got %h", $time, e.coef_linear, fit.coef_linear);
            failed = 1;
          end
          if (fit.coef_constant !== e.coef_constant) begin
            $display("%0t coef_constant exp %h got %h", $time, e.coef_constant,
                     fit.coef_constant);
            failed = 1;
          end
          if (fit.singular !== e.singular) begin
            $display("%0t singular exp %b got %b", $time, e.singular, fit.singular);
            failed = 1;
          end
          if (fit.point_count !== e.point_count) begin
            $display("%0t point_count exp %0d got %0d", $time, e.point_count,
                     fit.point_count);
            failed = 1;
          end
        end
        if (fits_seen == 4) begin
          // long hold-off while points keep coming
          fit_stall <= 1'b1;
          repeat (6000) @(posedge clk);
        end
      end
      fit_stall <= ($urandom_range(99) < recv_idle);
    end
  end

endmodule

>>> quadratic_least_squares_fit.f
rtl/qlsf_pkg.sv
rtl/quadratic_least_squares_fit.sv
sim/testbench.sv
